/* src/clns_pkg.sv */
`timescale 1ns / 1ps

package clns_pkg;

    // Request codes
    localparam logic [2:0] OP_INIT  = 3'd0;
    localparam logic [2:0] OP_CMD   = 3'd1;
    localparam logic [2:0] OP_DATA  = 3'd2;
    localparam logic [2:0] OP_CURS  = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    localparam logic [7:0]  SET_DDRAM   = 8'h80;
    localparam logic [7:0]  CLEAR_BYTE  = 8'h01;
    localparam logic [15:0] HOLD_US     = 16'd100;
    localparam logic [15:0] CLEAR_US    = 16'd2100;
    localparam logic [15:0] POWERUP_US  = 16'd50000;
    localparam logic [3:0]  INIT_LAST   = 4'd12;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] value;
        logic [6:0] col;
        logic [2:0] row;
    } t_req;

    typedef struct packed {
        logic        strobe_res;
        logic        reg_select;
        logic [3:0]  nibble;
        logic [15:0] wait_us;
        logic        last;
    } t_step;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic op_valid;
        logic last;
    } t_dp_sts;

    function automatic logic [7:0] row_base(input logic [1:0] r);
        logic [7:0] b;
        unique case (r)
            2'd0: b = 8'h00;
            2'd1: b = 8'h40;
            2'd2: b = 8'h14;
            default: b = 8'h54;
        endcase
        return b;
    endfunction

    // Power-up run: power-up wait, wake-up nibbles, function set, display on, entry mode, clear
    function automatic t_step init_step(input logic [3:0] k);
        t_step s;
        s.strobe_res = 1'b1;
        s.reg_select = 1'b0;
        s.wait_us    = HOLD_US;
        s.last       = (k == INIT_LAST);
        unique case (k)
            4'd0: begin
                s.strobe_res = 1'b0;
                s.nibble     = 4'h0;
                s.wait_us    = POWERUP_US;
            end
            4'd1: begin
                s.nibble  = 4'h3;
                s.wait_us = 16'd5100;
            end
            4'd2: begin
                s.nibble  = 4'h3;
                s.wait_us = 16'd250;
            end
            4'd3:  s.nibble = 4'h3;
            4'd4:  s.nibble = 4'h2;
            4'd5:  s.nibble = 4'h2;
            4'd6:  s.nibble = 4'h8;
            4'd7:  s.nibble = 4'h0;
            4'd8:  s.nibble = 4'hC;
            4'd9:  s.nibble = 4'h0;
            4'd10: s.nibble = 4'h6;
            4'd11: s.nibble = 4'h0;
            4'd12: begin
                s.nibble  = 4'h1;
                s.wait_us = CLEAR_US;
            end
            default: s.nibble = 4'h0;
        endcase
        return s;
    endfunction

endpackage

/* src/clns_stream_if.sv */
`timescale 1ns / 1ps

interface clns_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* src/clns_dpath.sv */
`timescale 1ns / 1ps

module clns_dpath #(
    parameter int ROWS = 4,
    parameter int COLS = 20
) (
    input  logic              i_clk,
    input  clns_pkg::t_req    i_req,
    input  clns_pkg::t_dp_cmd i_cmd,
    output clns_pkg::t_dp_sts o_sts,
    output clns_pkg::t_step   o_step
);

    logic [3:0] r_step_idx;
    logic       r_init;
    logic       r_rs;
    logic       r_extra;
    logic [7:0] r_byte;
    clns_pkg::t_step r_out;

    logic [2:0] row_c;
    logic [6:0] col_c;
    logic [7:0] n_byte;
    clns_pkg::t_step cur;

    // Clamp the cursor and form the byte: DDRAM address, clear command or request value
    always_comb begin
        row_c = (i_req.row >= 3'(ROWS)) ? 3'(ROWS - 1) : i_req.row;
        col_c = (i_req.col >= 7'(COLS)) ? 7'(COLS - 1) : i_req.col;
        unique case (i_req.op)
            clns_pkg::OP_CURS:
                n_byte = clns_pkg::SET_DDRAM
                       | ({1'b0, col_c} + clns_pkg::row_base(row_c[1:0]));
            clns_pkg::OP_CLEAR: n_byte = clns_pkg::CLEAR_BYTE;
            default:            n_byte = i_req.value;
        endcase
    end

    always_comb begin
        if (r_init) begin
            cur = clns_pkg::init_step(r_step_idx);
        end else begin
            cur.strobe_res = 1'b1;
            cur.reg_select = r_rs;
            cur.nibble     = r_step_idx[0] ? r_byte[3:0] : r_byte[7:4];
            cur.wait_us    = (r_step_idx[0] && r_extra) ? clns_pkg::CLEAR_US
                                                        : clns_pkg::HOLD_US;
            cur.last       = r_step_idx[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_step_idx <= 4'd0;
            r_init     <= (i_req.op == clns_pkg::OP_INIT);
            r_rs       <= (i_req.op == clns_pkg::OP_DATA);
            r_extra    <= (i_req.op == clns_pkg::OP_CLEAR);
            r_byte     <= n_byte;
        end else if (i_cmd.emit) begin
            r_step_idx <= r_step_idx + 4'd1;
        end
        if (i_cmd.emit) begin
            r_out <= cur;
        end
    end

    assign o_sts.op_valid = (i_req.op <= clns_pkg::OP_CLEAR);
    assign o_sts.last     = cur.last;
    assign o_step         = r_out;

endmodule

/* src/clns_ctrl.sv */
`timescale 1ns / 1ps

module clns_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  clns_pkg::t_dp_sts i_sts,
    output clns_pkg::t_dp_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    always_comb begin
        o_req_ready = (r_state == S_IDLE);
        o_cmd.load  = o_req_ready && i_req_valid;
        o_cmd.emit  = (r_state == S_RUN) && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    // drop unknown codes without a step
                    if (o_cmd.load && i_sts.op_valid) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (o_cmd.emit && i_sts.last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* src/char_lcd_nibble_sequencer.sv */
`timescale 1ns / 1ps
// A taken request moves the controller to S_RUN; each step is then registered in r_out.
// One step per cycle while the sink is ready; a request takes 2 steps (13 for init),
// and the next request is taken only once the controller is back in idle.
// The step counter in the datapath paces the run; unknown codes are dropped without a step.
// Reset (synchronous, active low) returns the controller to idle with no step pending.

module char_lcd_nibble_sequencer #(
    parameter int ROWS = 4,
    parameter int COLS = 20
) (
    input logic         i_clk,
    input logic         i_rst_n,
    clns_stream_if.sink   i_req,
    clns_stream_if.source o_step
);

    clns_pkg::t_dp_cmd s_cmd;
    clns_pkg::t_dp_sts s_sts;
    clns_pkg::t_req    s_req;
    clns_pkg::t_step   s_step;
    logic              s_req_ready;
    logic              s_out_valid;

    assign s_req = i_req.payload;

    // Sequencing: take a request when idle, then advance one step per free slot
    clns_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (s_req_ready),
        .o_out_valid (s_out_valid),
        .i_out_ready (o_step.ready),
        .i_sts       (s_sts),
        .o_cmd       (s_cmd)
    );

    // Latch the request byte, generate each step, hold it in the output register
    clns_dpath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dpath (
        .i_clk  (i_clk),
        .i_req  (s_req),
        .i_cmd  (s_cmd),
        .o_sts  (s_sts),
        .o_step (s_step)
    );

    assign i_req.ready    = s_req_ready;
    assign o_step.valid   = s_out_valid;
    assign o_step.payload = s_step;

    // A taken request with a known code makes the block busy on the next cycle
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && s_req_ready && s_sts.op_valid) |=> !s_req_ready)
        else $error("request taken but sequencer stayed idle");

    // Steps are only generated while a run is active
    a_no_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.emit |-> !s_req_ready)
        else $error("step generated while idle");

    // The only wait-only step is the power-up wait
    a_wait_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_out_valid && !s_step.strobe_res) |->
        (s_step.wait_us == clns_pkg::POWERUP_US && s_step.nibble == 4'h0
         && !s_step.reg_select))
        else $error("malformed wait-only step");

endmodule
